FILE: rtl/bkm_pkg.sv
// Package for the bottom-k MinHash sketch: sizes, hash constants, codes,
// item structs and state enums. No dependencies.
`default_nettype none
package bkm_pkg;

    localparam int KMER_LENGTH = 24;
    localparam int HEAP_DEPTH  = 4096;
    localparam int HEAP_AW     = $clog2(HEAP_DEPTH);
    localparam int SIZE_W      = HEAP_AW + 1;
    localparam int SEEN_W      = $clog2(KMER_LENGTH + 1);
    localparam int LANES       = KMER_LENGTH / 8;
    localparam int LANE_W      = $clog2(LANES);

    localparam logic [11:0] SKETCH_RESET = 12'd3000;
    localparam logic [11:0] COUNT_MAX    = 12'hFFF;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [63:0] XP1 = 64'h9E37_79B1_85EB_CA87;
    localparam logic [63:0] XP2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam logic [63:0] XP3 = 64'h1656_67B1_9E37_79F9;
    localparam logic [63:0] XP4 = 64'h85EB_CA77_C2B2_AE63;
    localparam logic [63:0] XP5 = 64'h27D4_EB2F_1656_67C5;

    // operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic CFG_SKETCH_LIMIT = 1'b0;
    localparam logic CFG_HASH_SEED    = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] base;
    } t_in_item;

    typedef struct packed {
        logic        kmer_ready;
        logic        inserted;
        logic [63:0] hash_value;
        logic [11:0] entry_count;
        logic        heap_empty;
    } t_out_item;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic        kmer;
        logic [63:0] hash;
    } t_cmd;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_HASH,
        FS_PUSH
    } t_fstate;

    // multiply step of the hash sequence
    typedef enum logic [2:0] {
        HK_LANE,
        HK_ROUND,
        HK_MIX,
        HK_AVAL1,
        HK_AVAL2
    } t_hkind;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_UP_RD,
        BS_UP_CMP,
        BS_DN_LAST,
        BS_DN_RD,
        BS_DN_CMP,
        BS_EMIT
    } t_bstate;

endpackage
`default_nettype wire

FILE: rtl/bkm_front.sv
// Front end: takes input items, keeps the base window and runs the k-mer hash
// on a shared 32x32 multiplier. Depends on bkm_pkg.
`default_nettype none
module bkm_front (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  bkm_pkg::t_in_item      i_data,
    input  wire  [63:0]            i_seed,
    output logic                   o_enq_valid,
    input  wire                    i_enq_ready,
    output bkm_pkg::t_cmd          o_enq_data
);

    bkm_pkg::t_fstate r_state, n_state;
    logic [7:0]  r_win [bkm_pkg::KMER_LENGTH];
    logic [7:0]  n_win [bkm_pkg::KMER_LENGTH];
    logic [bkm_pkg::SEEN_W-1:0] r_seen, n_seen;
    logic [63:0] r_h, n_h;
    logic [63:0] r_ma, n_ma;
    logic [63:0] r_acc, n_acc;
    logic [1:0]  r_part, n_part;
    bkm_pkg::t_hkind r_kind, n_kind;
    logic [bkm_pkg::LANE_W-1:0] r_lane, n_lane;
    bkm_pkg::t_cmd r_cmd, n_cmd;

    logic        w_acc;
    logic [63:0] w_lanes [bkm_pkg::LANES];
    logic [63:0] w_lane0_next;
    logic [63:0] w_b;
    logic [31:0] w_ma_part, w_mb_part;
    logic [63:0] w_prod;
    logic [63:0] w_mix;

    assign w_acc = i_valid && o_ready;

    // shift the window by one base
    always_comb begin
        for (int i = 0; i < bkm_pkg::KMER_LENGTH - 1; i++) begin
            n_win[i] = r_win[i + 1];
        end
        n_win[bkm_pkg::KMER_LENGTH-1] = i_data.base;
    end

    // little-endian lanes, oldest byte lowest
    always_comb begin
        for (int l = 0; l < bkm_pkg::LANES; l++) begin
            for (int b = 0; b < 8; b++) begin
                w_lanes[l][8*b +: 8] = r_win[8*l + b];
            end
        end
        for (int b = 0; b < 8; b++) begin
            w_lane0_next[8*b +: 8] = n_win[b];
        end
    end

    // pick the multiplier constant and the 32-bit partial product operands
    always_comb begin
        case (r_kind)
            bkm_pkg::HK_LANE:  w_b = bkm_pkg::XP2;
            bkm_pkg::HK_ROUND: w_b = bkm_pkg::XP1;
            bkm_pkg::HK_MIX:   w_b = bkm_pkg::XP1;
            bkm_pkg::HK_AVAL1: w_b = bkm_pkg::XP2;
            bkm_pkg::HK_AVAL2: w_b = bkm_pkg::XP3;
            default:           w_b = bkm_pkg::XP1;
        endcase
    end

    assign w_ma_part = (r_part == 2'd1) ? r_ma[63:32] : r_ma[31:0];
    assign w_mb_part = (r_part == 2'd2) ? w_b[63:32] : w_b[31:0];
    assign w_prod    = 64'(w_ma_part) * 64'(w_mb_part);
    assign w_mix     = r_acc + bkm_pkg::XP4;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bkm_pkg::FS_IDLE: begin
                if (w_acc) begin
                    if (i_data.operation == bkm_pkg::OP_PUSH &&
                        n_seen == bkm_pkg::SEEN_W'(bkm_pkg::KMER_LENGTH)) begin
                        n_state = bkm_pkg::FS_HASH;
                    end else begin
                        n_state = bkm_pkg::FS_PUSH;
                    end
                end
            end
            bkm_pkg::FS_HASH: begin
                if (r_part == 2'd3 && r_kind == bkm_pkg::HK_AVAL2) begin
                    n_state = bkm_pkg::FS_PUSH;
                end
            end
            bkm_pkg::FS_PUSH: begin
                if (i_enq_ready) begin
                    n_state = bkm_pkg::FS_IDLE;
                end
            end
            default: n_state = bkm_pkg::FS_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready     = (r_state == bkm_pkg::FS_IDLE);
        o_enq_valid = (r_state == bkm_pkg::FS_PUSH);
    end

    assign o_enq_data = r_cmd;

    // datapath next values
    always_comb begin
        n_seen = r_seen;
        n_h    = r_h;
        n_ma   = r_ma;
        n_acc  = r_acc;
        n_part = r_part;
        n_kind = r_kind;
        n_lane = r_lane;
        n_cmd  = r_cmd;
        case (r_state)
            bkm_pkg::FS_IDLE: begin
                if (i_data.operation == bkm_pkg::OP_PUSH) begin
                    n_seen = (r_seen < bkm_pkg::SEEN_W'(bkm_pkg::KMER_LENGTH))
                        ? r_seen + 1'b1 : r_seen;
                end else if (i_data.operation == bkm_pkg::OP_CLEAR) begin
                    n_seen = '0;
                end
                n_cmd.op   = i_data.operation;
                n_cmd.kmer = 1'b0;
                n_cmd.hash = '0;
                // start the hash: seed + prime 5 + length, first lane
                n_h    = i_seed + bkm_pkg::XP5 + 64'(bkm_pkg::KMER_LENGTH);
                n_ma   = w_lane0_next;
                n_part = 2'd0;
                n_kind = bkm_pkg::HK_LANE;
                n_lane = '0;
            end
            bkm_pkg::FS_HASH: begin
                n_part = r_part + 2'd1;
                case (r_part)
                    2'd0: n_acc = w_prod;
                    2'd1: n_acc = r_acc + {w_prod[31:0], 32'd0};
                    2'd2: n_acc = r_acc + {w_prod[31:0], 32'd0};
                    default: begin
                        // product is complete in r_acc: set up the next step
                        case (r_kind)
                            bkm_pkg::HK_LANE: begin
                                n_ma   = {r_acc[32:0], r_acc[63:33]};
                                n_kind = bkm_pkg::HK_ROUND;
                            end
                            bkm_pkg::HK_ROUND: begin
                                n_ma   = {(r_h[36:0] ^ r_acc[36:0]),
                                          (r_h[63:37] ^ r_acc[63:37])};
                                n_kind = bkm_pkg::HK_MIX;
                            end
                            bkm_pkg::HK_MIX: begin
                                n_h = w_mix;
                                if (r_lane == bkm_pkg::LANE_W'(bkm_pkg::LANES - 1)) begin
                                    n_ma   = w_mix ^ (w_mix >> 33);
                                    n_kind = bkm_pkg::HK_AVAL1;
                                end else begin
                                    n_lane = r_lane + 1'b1;
                                    n_ma   = w_lanes[r_lane + 1'b1];
                                    n_kind = bkm_pkg::HK_LANE;
                                end
                            end
                            bkm_pkg::HK_AVAL1: begin
                                n_ma   = r_acc ^ (r_acc >> 29);
                                n_kind = bkm_pkg::HK_AVAL2;
                            end
                            default: begin
                                n_cmd.op   = bkm_pkg::OP_PUSH;
                                n_cmd.kmer = 1'b1;
                                n_cmd.hash = r_acc ^ (r_acc >> 32);
                            end
                        endcase
                    end
                endcase
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bkm_pkg::FS_IDLE;
            r_seen  <= '0;
            r_part  <= '0;
            r_kind  <= bkm_pkg::HK_LANE;
            r_lane  <= '0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_kind  <= n_kind;
            r_lane  <= n_lane;
            if (w_acc) begin
                r_seen <= n_seen;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc && i_data.operation == bkm_pkg::OP_PUSH) begin
            r_win <= n_win;
        end
        r_h   <= n_h;
        r_ma  <= n_ma;
        r_acc <= n_acc;
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

FILE: rtl/bkm_cmd_fifo.sv
// Two-entry command queue between the front end and the heap engine.
// Depends on bkm_pkg.
`default_nettype none
module bkm_cmd_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  bkm_pkg::t_cmd  i_data,
    output logic           o_valid,
    input  wire            i_ready,
    output bkm_pkg::t_cmd  o_data
);

    bkm_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // hold entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bkm_heap.sv
// Back end: max-heap of the smallest hashes in a one-write two-read memory,
// sift up and sift down sequencer and the result register. Depends on bkm_pkg.
`default_nettype none
module bkm_heap (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [11:0]         i_limit,
    input  wire                 i_cmd_valid,
    output logic                o_cmd_ready,
    input  bkm_pkg::t_cmd       i_cmd,
    output logic                o_valid,
    input  wire                 i_ready,
    output bkm_pkg::t_out_item  o_data
);

    localparam int AW = bkm_pkg::HEAP_AW;
    localparam int SW = bkm_pkg::SIZE_W;

    bkm_pkg::t_bstate r_state, n_state;
    logic [63:0]  r_heap [bkm_pkg::HEAP_DEPTH];
    logic [63:0]  r_rd0, r_rd1;
    logic [SW-1:0] r_size, n_size;
    logic [11:0]  r_cnt, n_cnt;
    logic [63:0]  r_top, n_top;
    logic [AW-1:0] r_i, n_i;
    logic [63:0]  r_v, n_v;
    logic [63:0]  r_last, n_last;
    logic         r_then_add, n_then_add;
    logic         r_kmer, n_kmer, r_ins, n_ins, r_empty, n_empty;
    logic [63:0]  r_hv, n_hv;
    logic         r_ovalid;
    bkm_pkg::t_out_item r_out;

    logic          w_we;
    logic [AW-1:0] w_wa, w_ra0, w_ra1;
    logic [63:0]   w_wd;

    // command classification
    logic [63:0] w_cur_top;
    logic        w_is_push, w_is_pop, w_is_clear, w_hit, w_room, w_small;
    // sift helpers
    logic [AW+1:0] w_c, w_c1;
    logic          w_leaf, w_use1;
    logic [63:0]   w_child;
    logic [AW-1:0] w_child_idx, w_up;
    logic [63:0]   w_pv;
    logic          w_emit_ok;

    assign w_cur_top  = (r_size != '0) ? r_top : bkm_pkg::ALL_ONES;
    assign w_is_push  = (i_cmd.op == bkm_pkg::OP_PUSH) && i_cmd.kmer;
    assign w_is_pop   = (i_cmd.op == bkm_pkg::OP_POP);
    assign w_is_clear = (i_cmd.op == bkm_pkg::OP_CLEAR);
    assign w_hit      = i_cmd.hash < w_cur_top;
    assign w_room     = (r_cnt < i_limit) && (r_size < SW'(bkm_pkg::HEAP_DEPTH));
    assign w_small    = (r_size <= SW'(1));

    assign w_c        = {1'b0, r_i, 1'b1};
    assign w_c1       = w_c + 1'b1;
    assign w_leaf     = w_c >= (AW+2)'(r_size);
    assign w_use1     = (w_c1 < (AW+2)'(r_size)) && (r_rd1 > r_rd0);
    assign w_child    = w_use1 ? r_rd1 : r_rd0;
    assign w_child_idx = w_use1 ? w_c1[AW-1:0] : w_c[AW-1:0];
    assign w_up       = (r_i - 1'b1) >> 1;
    assign w_pv       = (w_up == '0) ? r_top : r_rd0;
    assign w_emit_ok  = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bkm_pkg::BS_IDLE: begin
                if (i_cmd_valid) begin
                    if (w_is_pop && r_size != '0 && !w_small) begin
                        n_state = bkm_pkg::BS_DN_LAST;
                    end else if (w_is_push && w_hit) begin
                        if (w_room || w_small) begin
                            n_state = bkm_pkg::BS_UP_RD;
                        end else begin
                            n_state = bkm_pkg::BS_DN_LAST;
                        end
                    end else begin
                        n_state = bkm_pkg::BS_EMIT;
                    end
                end
            end
            bkm_pkg::BS_UP_RD: begin
                n_state = (r_i == '0) ? bkm_pkg::BS_EMIT : bkm_pkg::BS_UP_CMP;
            end
            bkm_pkg::BS_UP_CMP: begin
                n_state = (w_pv >= r_v) ? bkm_pkg::BS_EMIT : bkm_pkg::BS_UP_RD;
            end
            bkm_pkg::BS_DN_LAST: n_state = bkm_pkg::BS_DN_RD;
            bkm_pkg::BS_DN_RD: begin
                if (w_leaf) begin
                    n_state = r_then_add ? bkm_pkg::BS_UP_RD : bkm_pkg::BS_EMIT;
                end else begin
                    n_state = bkm_pkg::BS_DN_CMP;
                end
            end
            bkm_pkg::BS_DN_CMP: begin
                if (w_child <= r_last) begin
                    n_state = r_then_add ? bkm_pkg::BS_UP_RD : bkm_pkg::BS_EMIT;
                end else begin
                    n_state = bkm_pkg::BS_DN_RD;
                end
            end
            bkm_pkg::BS_EMIT: begin
                if (w_emit_ok) begin
                    n_state = bkm_pkg::BS_IDLE;
                end
            end
            default: n_state = bkm_pkg::BS_IDLE;
        endcase
    end

    // datapath, memory control and outputs
    always_comb begin
        o_cmd_ready = (r_state == bkm_pkg::BS_IDLE);
        n_size     = r_size;
        n_cnt      = r_cnt;
        n_i        = r_i;
        n_v        = r_v;
        n_last     = r_last;
        n_then_add = r_then_add;
        n_kmer     = r_kmer;
        n_ins      = r_ins;
        n_empty    = r_empty;
        n_hv       = r_hv;
        w_we       = 1'b0;
        w_wa       = r_i;
        w_wd       = r_v;
        w_ra0      = r_size[AW-1:0] - 1'b1;
        w_ra1      = w_c1[AW-1:0];
        case (r_state)
            bkm_pkg::BS_IDLE: begin
                n_kmer     = 1'b0;
                n_ins      = 1'b0;
                n_empty    = 1'b0;
                n_hv       = '0;
                n_then_add = 1'b0;
                n_v        = i_cmd.hash;
                if (i_cmd_valid) begin
                    if (w_is_clear) begin
                        n_size = SW'(1);
                        n_cnt  = '0;
                    end else if (w_is_pop) begin
                        if (r_size == '0) begin
                            n_empty = 1'b1;
                        end else begin
                            n_hv   = r_top;
                            n_size = r_size - 1'b1;
                            // a single entry leaves an empty heap at once
                            if (w_small && r_cnt != '0) begin
                                n_cnt = '0;
                            end
                        end
                    end else if (w_is_push) begin
                        n_kmer = 1'b1;
                        n_hv   = i_cmd.hash;
                        if (w_hit) begin
                            n_ins = 1'b1;
                            if (w_room) begin
                                n_i    = r_size[AW-1:0];
                                n_size = r_size + 1'b1;
                                if (r_cnt != bkm_pkg::COUNT_MAX) begin
                                    n_cnt = r_cnt + 1'b1;
                                end
                            end else if (w_small) begin
                                // removing the top empties the heap: add at the root
                                n_i    = '0;
                                n_size = SW'(1);
                            end else begin
                                n_size     = r_size - 1'b1;
                                n_then_add = 1'b1;
                            end
                        end
                    end
                end
            end
            bkm_pkg::BS_UP_RD: begin
                w_ra0 = w_up;
                if (r_i == '0) begin
                    w_we = 1'b1;
                end
            end
            bkm_pkg::BS_UP_CMP: begin
                w_we = 1'b1;
                if (w_pv < r_v) begin
                    w_wd = w_pv;
                    n_i  = w_up;
                end
            end
            bkm_pkg::BS_DN_LAST: begin
                n_last = r_rd0;
                n_i    = '0;
            end
            bkm_pkg::BS_DN_RD: begin
                w_ra0 = w_c[AW-1:0];
                w_ra1 = w_c1[AW-1:0];
                w_wd  = r_last;
                if (w_leaf) begin
                    w_we = 1'b1;
                end
            end
            bkm_pkg::BS_DN_CMP: begin
                w_we = 1'b1;
                if (w_child <= r_last) begin
                    w_wd = r_last;
                end else begin
                    w_wd = w_child;
                    n_i  = w_child_idx;
                end
            end
            default: ;
        endcase
        // end of a removal: chain the add, or clamp the count after a pop
        if ((r_state == bkm_pkg::BS_DN_RD && w_leaf) ||
            (r_state == bkm_pkg::BS_DN_CMP && w_child <= r_last)) begin
            if (r_then_add) begin
                n_i    = r_size[AW-1:0];
                n_size = r_size + 1'b1;
            end else if (r_cnt > r_size[11:0]) begin
                n_cnt = r_size[11:0];
            end
        end
        // keep the root cached in a register
        n_top = r_top;
        if (r_state == bkm_pkg::BS_IDLE && i_cmd_valid && w_is_clear) begin
            n_top = bkm_pkg::ALL_ONES;
        end else if (w_we && w_wa == '0) begin
            n_top = w_wd;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // heap memory: one write, two registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heap[w_wa] <= w_wd;
        end
        r_rd0 <= r_heap[w_ra0];
        r_rd1 <= r_heap[w_ra1];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= bkm_pkg::BS_IDLE;
            r_size     <= SW'(1);
            r_cnt      <= '0;
            r_top      <= bkm_pkg::ALL_ONES;
            r_ovalid   <= 1'b0;
            r_then_add <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_size     <= n_size;
            r_cnt      <= n_cnt;
            r_top      <= n_top;
            r_then_add <= n_then_add;
            if (r_state == bkm_pkg::BS_EMIT && w_emit_ok) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_v     <= n_v;
        r_last  <= n_last;
        r_kmer  <= n_kmer;
        r_ins   <= n_ins;
        r_empty <= n_empty;
        r_hv    <= n_hv;
        if (r_state == bkm_pkg::BS_EMIT && w_emit_ok) begin
            r_out.kmer_ready  <= r_kmer;
            r_out.inserted    <= r_ins;
            r_out.hash_value  <= r_hv;
            r_out.entry_count <= r_cnt;
            r_out.heap_empty  <= r_empty;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/bottom_k_minhash_sketch.sv
// Bottom-k MinHash sketch: front end, command queue, heap engine, config registers.
// Push with a full window: the hash takes 11 multiplies, each built from 32-bit partial
// products on one 32x32 multiplier; then the back end walks the heap a level at a time:
// sift up to add, or sift down and then sift up when the top is removed first.
// Pops that leave entries behind walk the heap with a sift down.
// Throughput is set by the hash multiplier and the heap memory port, overlapped by the queue.
// Reset (synchronous, active low): empty window, heap holds only the all-ones root.
`default_nettype none
module bottom_k_minhash_sketch (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  bkm_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output bkm_pkg::t_out_item  o_out_data,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire                 i_cfg_index,
    input  wire  [63:0]         i_cfg_data
);

    logic [11:0] r_limit;
    logic [63:0] r_seed;
    logic          w_enq_valid, w_enq_ready, w_deq_valid, w_deq_ready;
    bkm_pkg::t_cmd w_enq_data, w_deq_data;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bkm_pkg::SKETCH_RESET;
            r_seed  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bkm_pkg::CFG_SKETCH_LIMIT: r_limit <= i_cfg_data[11:0];
                bkm_pkg::CFG_HASH_SEED:    r_seed  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bkm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .i_seed      (r_seed),
        .o_enq_valid (w_enq_valid),
        .i_enq_ready (w_enq_ready),
        .o_enq_data  (w_enq_data)
    );

    bkm_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_enq_valid),
        .o_ready (w_enq_ready),
        .i_data  (w_enq_data),
        .o_valid (w_deq_valid),
        .i_ready (w_deq_ready),
        .o_data  (w_deq_data)
    );

    bkm_heap u_heap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_limit     (r_limit),
        .i_cmd_valid (w_deq_valid),
        .o_cmd_ready (w_deq_ready),
        .i_cmd       (w_deq_data),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule
`default_nettype wire
